// ===== src/sspq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable sorted priority queue package
// Shared types and constants for the queue cells and the top level.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int unsigned KeyBits     = 16;
  localparam int unsigned PayloadBits = 16;
  localparam int unsigned CountBits   = 5;

  typedef enum logic [0:0] {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OpHold   = 2'd0,
    OpInsert = 2'd1,
    OpRemove = 2'd2
  } op_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [KeyBits-1:0]     key;
    logic [PayloadBits-1:0] payload;
  } sspq_req_t;

  typedef struct packed {
    logic                   head_valid;
    logic [KeyBits-1:0]     head_key;
    logic [PayloadBits-1:0] head_payload;
    logic [CountBits-1:0]   entry_count;
    logic                   dropped;
  } sspq_rsp_t;

  typedef struct packed {
    logic                   valid;
    logic [KeyBits-1:0]     key;
    logic [PayloadBits-1:0] payload;
  } sspq_entry_t;

  typedef struct packed {
    op_e                    op;
    logic                   order_mode;
    logic [KeyBits-1:0]     key;
    logic [PayloadBits-1:0] payload;
  } sspq_ctrl_t;

endpackage

// ===== src/sspq_cell.sv =====
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry and either keeps it, takes the new word, takes its left
// neighbor's entry on an insert, or takes its right neighbor's on a removal.
// ----------------------------------------------------------------------------
module sspq_cell import sspq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sspq_ctrl_t  ctrl_i,
  input  sspq_entry_t left_i,
  input  sspq_entry_t right_i,
  input  logic        found_i,
  output logic        found_o,
  output sspq_entry_t entry_o
);

  logic                   valid_q, valid_d;
  logic [KeyBits-1:0]     key_q, key_d;
  logic [PayloadBits-1:0] payload_q, payload_d;
  logic                   match;

  // The insert position is the first cell that is empty or, in ordered mode,
  // holds a strictly greater key.
  assign match   = !valid_q || (ctrl_i.order_mode && (key_q > ctrl_i.key));
  assign found_o = found_i || match;

  always_comb begin
    valid_d   = valid_q;
    key_d     = key_q;
    payload_d = payload_q;
    unique case (ctrl_i.op)
      OpInsert: begin
        if (found_i) begin
          valid_d   = left_i.valid;
          key_d     = left_i.key;
          payload_d = left_i.payload;
        end else if (match) begin
          valid_d   = 1'b1;
          key_d     = ctrl_i.key;
          payload_d = ctrl_i.payload;
        end
      end
      OpRemove: begin
        valid_d   = right_i.valid;
        key_d     = right_i.key;
        payload_d = right_i.payload;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, payload: payload_q};

endmodule

// ===== src/stable_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Stable sorted priority queue
// Bounded priority queue kept as a sorted row of cells, head in cell zero.
// ----------------------------------------------------------------------------
// The queue takes one insert or removal word in every clock cycle and never
// raises busy. Each accepted word yields exactly one result on the cycle after
// acceptance, marked by result_valid_o; the receiver cannot stall it. The
// insert position is resolved combinationally by a found chain that runs through
// all CAPACITY cells, so that chain sets the clock rate for large capacities.
module stable_sorted_priority_queue import sspq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  sspq_req_t req_i,
  output logic      result_valid_o,
  output sspq_rsp_t rsp_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            order_mode_q;
  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;
  logic            strobe_q;
  logic            accept;
  logic            full;
  logic            empty;
  sspq_ctrl_t      ctrl;
  sspq_entry_t     cells [CAPACITY];
  logic [CAPACITY:0] found;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign full        = (count_q == CntW'(CAPACITY));
  assign empty       = (count_q == '0);

  always_comb begin
    ctrl.op         = OpHold;
    ctrl.order_mode = order_mode_q;
    ctrl.key        = req_i.key;
    ctrl.payload    = req_i.payload;
    count_d         = count_q;
    dropped_d       = 1'b0;
    if (accept) begin
      unique case (req_i.cmd)
        CmdInsert: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            ctrl.op = OpInsert;
            count_d = count_q + 1'b1;
          end
        end
        CmdRemove: begin
          if (!empty) begin
            ctrl.op = OpRemove;
            count_d = count_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sspq_entry_t left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_left
      assign left = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_right
      assign right = cells[i+1];
    end
    sspq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .entry_o (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q <= 1'b1;
      count_q      <= '0;
      dropped_q    <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        order_mode_q <= cfg_data_i;
      end
      count_q   <= count_d;
      dropped_q <= dropped_d;
      strobe_q  <= accept;
    end
  end

  assign result_valid_o     = strobe_q;
  assign rsp_o.head_valid   = cells[0].valid;
  assign rsp_o.head_key     = cells[0].valid ? cells[0].key : '0;
  assign rsp_o.head_payload = cells[0].valid ? cells[0].payload : '0;
  assign rsp_o.entry_count  = CountBits'(count_q);
  assign rsp_o.dropped      = dropped_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_head_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cells[0].valid == (count_q != '0))
    else $error("Head cell valid disagrees with entry count.");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.cmd == CmdInsert && !full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Accepted insert did not add an entry.");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !(req_i.cmd == CmdInsert && full)) |=> !dropped_q)
    else $error("Drop flagged on a word that was not a full insert.");

  a_tail_empty_when_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> !cells[CAPACITY-1].valid)
    else $error("Last cell holds an entry while the queue is not full.");

endmodule

// ===== test/sspq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue result checker
// Keeps its own copy of the queue contents and order mode. From each accepted
// command word it predicts the result word, then compares every returned
// result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sspq_checker import sspq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  sspq_req_t   req_i,
  input  logic        result_valid_i,
  input  sspq_rsp_t   rsp_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned drops_o,
  output int unsigned empty_removes_o
);

  logic [KeyBits-1:0]     queue_key     [CAPACITY];
  logic [PayloadBits-1:0] queue_payload [CAPACITY];
  int unsigned            queue_fill;
  logic                   ordered_q;
  sspq_rsp_t              expected_rsp_q[$];

  task automatic apply_word(input sspq_req_t w, output sspq_rsp_t r);
    int unsigned pos;
    int unsigned i;
    bit          found;
    r = '0;
    if (w.cmd == CmdInsert) begin
      if (queue_fill >= CAPACITY) begin
        r.dropped = 1'b1;
        drops_o++;
      end else begin
        pos = queue_fill;
        found = 1'b0;
        if (ordered_q) begin
          for (i = 0; i < queue_fill; i++) begin
            if (!found && queue_key[i] > w.key) begin
              pos = i;
              found = 1'b1;
            end
          end
        end
        for (i = queue_fill; i > pos; i--) begin
          queue_key[i]     = queue_key[i-1];
          queue_payload[i] = queue_payload[i-1];
        end
        queue_key[pos]     = w.key;
        queue_payload[pos] = w.payload;
        queue_fill++;
      end
    end else if (queue_fill > 0) begin
      for (i = 0; i + 1 < queue_fill; i++) begin
        queue_key[i]     = queue_key[i+1];
        queue_payload[i] = queue_payload[i+1];
      end
      queue_fill--;
    end else begin
      empty_removes_o++;
    end
    if (queue_fill > 0) begin
      r.head_valid   = 1'b1;
      r.head_key     = queue_key[0];
      r.head_payload = queue_payload[0];
    end
    r.entry_count = queue_fill[CountBits-1:0];
  endtask

  task automatic note_mismatch(input string what, input sspq_rsp_t exp_w,
                               input sspq_rsp_t act_w);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected valid=%0b key=%h payload=%h count=%0d dropped=%0b",
               exp_w.head_valid, exp_w.head_key, exp_w.head_payload,
               exp_w.entry_count, exp_w.dropped);
      $display("  actual   valid=%0b key=%h payload=%h count=%0d dropped=%0b",
               act_w.head_valid, act_w.head_key, act_w.head_payload,
               act_w.entry_count, act_w.dropped);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sspq_rsp_t expected;
    sspq_rsp_t predicted;
    if (!rst_ni) begin
      queue_fill = 0;
      ordered_q = 1'b1;
      expected_rsp_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      drops_o = 0;
      empty_removes_o = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_rsp_q.size() == 0) begin
          note_mismatch("result word with no command outstanding", '0, rsp_i);
        end else begin
          expected = expected_rsp_q.pop_front();
          if (rsp_i.head_valid !== expected.head_valid
              || rsp_i.head_key !== expected.head_key
              || rsp_i.head_payload !== expected.head_payload
              || rsp_i.entry_count !== expected.entry_count
              || rsp_i.dropped !== expected.dropped) begin
            note_mismatch("queue result word differs", expected, rsp_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        ordered_q = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        apply_word(req_i, predicted);
        expected_rsp_q.push_back(predicted);
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue testbench
// Drives directed and random insert and remove words through the queue under
// both order modes, with random gaps between words, while the checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import sspq_pkg::*;

  localparam int unsigned Capacity     = 16;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseWords   = 179;
  localparam logic        ModeFifo     = 1'b0;
  localparam logic        ModeOrdered  = 1'b1;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  sspq_req_t req_i;
  logic      result_valid_o;
  sspq_rsp_t rsp_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned drops;
  int unsigned empty_removes;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned mode_writes = 0;

  logic [KeyBits-1:0] dir_keys [16] = '{
    16'hFFFF, 16'h0000, 16'h0005, 16'h0005, 16'h0005, 16'hFFFF, 16'h0000, 16'h0007,
    16'h0003, 16'h0003, 16'h8000, 16'h7FFF, 16'h0001, 16'h0002, 16'h0005, 16'h0000
  };

  stable_sorted_priority_queue #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .result_valid_o,
    .rsp_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  sspq_checker #(
    .CAPACITY(Capacity)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .start_i        (start),
    .busy_i         (busy),
    .req_i,
    .result_valid_i (result_valid_o),
    .rsp_i          (rsp_o),
    .cfg_valid_i,
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i,
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .drops_o        (drops),
    .empty_removes_o(empty_removes)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("stable_sorted_priority_queue: mismatch");
      $finish;
    end
  end

  function automatic logic [KeyBits-1:0] pick_key();
    logic [KeyBits-1:0] r;
    r = KeyBits'($urandom);
    case ($urandom_range(0, 5))
      0: r = '0;
      1: r = '1;
      2, 3: r = KeyBits'($urandom_range(0, 7));
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input cmd_e c, input logic [KeyBits-1:0] k,
                           input logic [PayloadBits-1:0] p);
    @(negedge clk_i);
    start = 1'b1;
    req_i.cmd = c;
    req_i.key = k;
    req_i.payload = p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic idle_for(input int unsigned n);
    @(negedge clk_i);
    start = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i = m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    mode_writes++;
  endtask

  initial begin
    int unsigned        done;
    int unsigned        seg_len;
    int unsigned        ins_pct;
    int unsigned        j;
    bit                 idle_on;
    logic [KeyBits-1:0] rk;
    logic [PayloadBits-1:0] rp;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(ModeOrdered);
    send_word(CmdRemove, '1, '1);
    for (int i = 0; i < 16; i++) begin
      rp = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : PayloadBits'(i * 16'h1111);
      send_word(CmdInsert, dir_keys[i], rp);
    end
    send_word(CmdInsert, 16'h0001, 16'hABCD);
    send_word(CmdRemove, '0, '0);
    send_word(CmdRemove, '0, '0);
    write_mode(ModeFifo);
    send_word(CmdInsert, 16'h0000, 16'h5A5A);
    send_word(CmdInsert, 16'hFFFF, 16'hA5A5);
    send_word(CmdInsert, 16'h0000, 16'h0F0F);

    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph < 4) begin
        write_mode((ph % 2 == 0) ? ModeOrdered : ModeFifo);
      end else begin
        write_mode($urandom_range(0, 1) ? ModeOrdered : ModeFifo);
      end
      done = 0;
      while (done < PhaseWords) begin
        seg_len = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0: ins_pct = 80;
          1: ins_pct = 20;
          default: ins_pct = 50;
        endcase
        idle_on = (ph != RandomPhases - 1) && ($urandom_range(0, 1) == 1);
        for (j = 0; j < seg_len && done < PhaseWords; j++) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            idle_for($urandom_range(1, 19));
          end
          rk = pick_key();
          rp = PayloadBits'($urandom);
          if ($urandom_range(0, 99) < ins_pct) begin
            send_word(CmdInsert, rk, rp);
          end else begin
            send_word(CmdRemove, KeyBits'($urandom), rp);
          end
          done++;
        end
      end
    end

    drain();
    repeat (4) @(negedge clk_i);
    $display("Sent %0d command words across %0d order mode writes, FIFO and sorted.",
             words_sent, mode_writes);
    $display("%0d inserts were refused at full capacity and %0d removes found it empty.",
             drops, empty_removes);
    if (fail_count == 0) begin
      $display("stable_sorted_priority_queue: match");
    end else begin
      $display("stable_sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sspq_pkg.sv
src/sspq_cell.sv
src/stable_sorted_priority_queue.sv
test/sspq_checker.sv
test/tb_top.sv
